### src/sgi_pkg.sv
// sgi_pkg: shared types and constants of the segment intersection unit
`timescale 1ns / 1ps
package sgi_pkg;

   // coordinate width, signed fixed point (fraction bits do not enter the math)
   localparam int CW = 16;
   // determinant width: difference products plus one subtract
   localparam int DW = 2 * CW + 3;
   // numerator width: cross products times differences plus one subtract
   localparam int NW = 3 * CW + 3;
   // queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef struct packed {
      logic signed [CW-1:0] ax0;
      logic signed [CW-1:0] ay0;
      logic signed [CW-1:0] ax1;
      logic signed [CW-1:0] ay1;
      logic signed [CW-1:0] bx0;
      logic signed [CW-1:0] by0;
      logic signed [CW-1:0] bx1;
      logic signed [CW-1:0] by1;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic signed [CW-1:0] cross_x;
      logic signed [CW-1:0] cross_y;
   } rsp_type;

   typedef struct packed {
      logic signed [CW-1:0] ax_lo;
      logic signed [CW-1:0] ax_hi;
      logic signed [CW-1:0] ay_lo;
      logic signed [CW-1:0] ay_hi;
      logic signed [CW-1:0] bx_lo;
      logic signed [CW-1:0] bx_hi;
      logic signed [CW-1:0] by_lo;
      logic signed [CW-1:0] by_hi;
   } bounds_type;

   // one classified pair, ready for division
   typedef struct packed {
      logic           det_zero;
      logic           neg_x;
      logic           neg_y;
      logic [NW-1:0]  nm_x;
      logic [NW-1:0]  nm_y;
      logic [DW-1:0]  dm;
      bounds_type     bnd;
   } entry_type;

   // queue status seen by its neighbors
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### src/sgi_front.sv
// sgi_front: accepts segment pairs and forms determinant and numerators
`timescale 1ns / 1ps
module sgi_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sgi_pkg::req_type          req_data,
   input  sgi_pkg::queue_status_type qstat,
   output logic                      push,
   output sgi_pkg::entry_type        push_data
);

   localparam int CW = sgi_pkg::CW;
   localparam int DW = sgi_pkg::DW;
   localparam int NW = sgi_pkg::NW;
   localparam int PW = NW - 1;

   typedef struct packed {
      logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
      logic signed [CW:0]   dxa, dya, dxb, dyb;
      sgi_pkg::bounds_type  bnd;
   } s1_type;

   typedef struct packed {
      logic signed [2*CW+1:0] pd1, pd2;
      logic signed [2*CW-1:0] pa1, pa2, pb1, pb2;
      logic signed [CW:0]     dxa, dya, dxb, dyb;
      sgi_pkg::bounds_type    bnd;
   } s2_type;

   typedef struct packed {
      logic signed [DW-1:0]   det;
      logic signed [2*CW:0]   pa, pb;
      logic signed [CW:0]     dxa, dya, dxb, dyb;
      sgi_pkg::bounds_type    bnd;
   } s3_type;

   typedef struct packed {
      logic                 det_zero;
      logic                 det_neg;
      logic [DW-1:0]        dm;
      logic signed [PW-1:0] px1, px2, py1, py2;
      sgi_pkg::bounds_type  bnd;
   } s4_type;

   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   s4_type             s4_ff, s4_in;
   sgi_pkg::entry_type s5_ff, s5_in;
   logic [4:0]         vld_ff, vld_in;
   logic               en;
   logic signed [NW-1:0] nx, ny;

   // whole front advances unless its last stage is blocked by a full queue
   assign en        = !(vld_ff[4] && qstat.full);
   assign req_ready = en;
   assign push      = vld_ff[4] && !qstat.full;
   assign push_data = s5_ff;
   assign vld_in    = {vld_ff[3:0], req_valid};

   always_comb begin
      s1_in.x1  = req_data.ax0;
      s1_in.y1  = req_data.ay0;
      s1_in.x2  = req_data.ax1;
      s1_in.y2  = req_data.ay1;
      s1_in.x3  = req_data.bx0;
      s1_in.y3  = req_data.by0;
      s1_in.x4  = req_data.bx1;
      s1_in.y4  = req_data.by1;
      s1_in.dxa = (CW+1)'(req_data.ax0) - (CW+1)'(req_data.ax1);
      s1_in.dya = (CW+1)'(req_data.ay0) - (CW+1)'(req_data.ay1);
      s1_in.dxb = (CW+1)'(req_data.bx0) - (CW+1)'(req_data.bx1);
      s1_in.dyb = (CW+1)'(req_data.by0) - (CW+1)'(req_data.by1);
      s1_in.bnd.ax_lo = (req_data.ax0 < req_data.ax1) ? req_data.ax0 : req_data.ax1;
      s1_in.bnd.ax_hi = (req_data.ax0 < req_data.ax1) ? req_data.ax1 : req_data.ax0;
      s1_in.bnd.ay_lo = (req_data.ay0 < req_data.ay1) ? req_data.ay0 : req_data.ay1;
      s1_in.bnd.ay_hi = (req_data.ay0 < req_data.ay1) ? req_data.ay1 : req_data.ay0;
      s1_in.bnd.bx_lo = (req_data.bx0 < req_data.bx1) ? req_data.bx0 : req_data.bx1;
      s1_in.bnd.bx_hi = (req_data.bx0 < req_data.bx1) ? req_data.bx1 : req_data.bx0;
      s1_in.bnd.by_lo = (req_data.by0 < req_data.by1) ? req_data.by0 : req_data.by1;
      s1_in.bnd.by_hi = (req_data.by0 < req_data.by1) ? req_data.by1 : req_data.by0;
   end

   always_comb begin
      s2_in.pd1 = (2*CW+2)'(s1_ff.dxa) * (2*CW+2)'(s1_ff.dyb);
      s2_in.pd2 = (2*CW+2)'(s1_ff.dya) * (2*CW+2)'(s1_ff.dxb);
      s2_in.pa1 = (2*CW)'(s1_ff.x1) * (2*CW)'(s1_ff.y2);
      s2_in.pa2 = (2*CW)'(s1_ff.y1) * (2*CW)'(s1_ff.x2);
      s2_in.pb1 = (2*CW)'(s1_ff.x3) * (2*CW)'(s1_ff.y4);
      s2_in.pb2 = (2*CW)'(s1_ff.y3) * (2*CW)'(s1_ff.x4);
      s2_in.dxa = s1_ff.dxa;
      s2_in.dya = s1_ff.dya;
      s2_in.dxb = s1_ff.dxb;
      s2_in.dyb = s1_ff.dyb;
      s2_in.bnd = s1_ff.bnd;
   end

   always_comb begin
      s3_in.det = DW'(s2_ff.pd1) - DW'(s2_ff.pd2);
      s3_in.pa  = (2*CW+1)'(s2_ff.pa1) - (2*CW+1)'(s2_ff.pa2);
      s3_in.pb  = (2*CW+1)'(s2_ff.pb1) - (2*CW+1)'(s2_ff.pb2);
      s3_in.dxa = s2_ff.dxa;
      s3_in.dya = s2_ff.dya;
      s3_in.dxb = s2_ff.dxb;
      s3_in.dyb = s2_ff.dyb;
      s3_in.bnd = s2_ff.bnd;
   end

   always_comb begin
      s4_in.det_zero = (s3_ff.det == '0);
      s4_in.det_neg  = s3_ff.det[DW-1];
      s4_in.dm       = s3_ff.det[DW-1] ? DW'(-s3_ff.det) : DW'(s3_ff.det);
      s4_in.px1      = PW'(s3_ff.pa) * PW'(s3_ff.dxb);
      s4_in.px2      = PW'(s3_ff.dxa) * PW'(s3_ff.pb);
      s4_in.py1      = PW'(s3_ff.pa) * PW'(s3_ff.dyb);
      s4_in.py2      = PW'(s3_ff.dya) * PW'(s3_ff.pb);
      s4_in.bnd      = s3_ff.bnd;
   end

   always_comb begin
      nx = NW'(s4_ff.px1) - NW'(s4_ff.px2);
      ny = NW'(s4_ff.py1) - NW'(s4_ff.py2);
      s5_in.det_zero = s4_ff.det_zero;
      s5_in.neg_x    = nx[NW-1] ^ s4_ff.det_neg;
      s5_in.neg_y    = ny[NW-1] ^ s4_ff.det_neg;
      s5_in.nm_x     = nx[NW-1] ? NW'(-nx) : NW'(nx);
      s5_in.nm_y     = ny[NW-1] ? NW'(-ny) : NW'(ny);
      s5_in.dm       = s4_ff.dm;
      s5_in.bnd      = s4_ff.bnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

endmodule

### src/sgi_queue.sv
// sgi_queue: short queue between the front and the back
`timescale 1ns / 1ps
module sgi_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sgi_pkg::entry_type        push_data,
   input  logic                      pop,
   output sgi_pkg::entry_type        head,
   output sgi_pkg::queue_status_type qstat
);

   localparam int DEPTH = sgi_pkg::QUEUE_DEPTH;
   localparam int QPW   = sgi_pkg::QPW;

   sgi_pkg::entry_type mem_ff [DEPTH];
   logic [QPW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QPW:0]       cnt_ff, cnt_in;

   assign head        = mem_ff[rd_ff];
   assign qstat.full  = (cnt_ff == (QPW+1)'(DEPTH));
   assign qstat.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### src/sgi_back.sv
// sgi_back: pipelined division, bounds check and result register
`timescale 1ns / 1ps
module sgi_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sgi_pkg::queue_status_type qstat,
   input  sgi_pkg::entry_type        head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sgi_pkg::rsp_type          rsp_data
);

   localparam int CW = sgi_pkg::CW;
   localparam int NW = sgi_pkg::NW;

   typedef struct packed {
      sgi_pkg::entry_type e;
      logic               ovf;
      logic [NW-1:0]      rem_x;
      logic [NW-1:0]      rem_y;
      logic [CW-1:0]      q_x;
      logic [CW-1:0]      q_y;
   } stage_type;

   stage_type        st_ff [CW+1];
   stage_type        st_in [CW+1];
   logic [CW:0]      vld_ff;
   logic             en;
   logic             rsp_valid_ff;
   sgi_pkg::rsp_type rsp_ff, rsp_in;
   logic [NW-1:0]    dm_top;
   logic signed [CW:0] qs_x, qs_y;
   logic             hit;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop       = en && !qstat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a quotient of 2^CW or more in magnitude cannot lie in any bound
   assign dm_top = NW'(head.dm) << CW;

   always_comb begin
      st_in[0].e     = head;
      st_in[0].ovf   = (head.nm_x >= dm_top) || (head.nm_y >= dm_top);
      st_in[0].rem_x = head.nm_x;
      st_in[0].rem_y = head.nm_y;
      st_in[0].q_x   = '0;
      st_in[0].q_y   = '0;
   end

   for (genvar k = 1; k <= CW; k++) begin : g_div
      logic [NW-1:0] sh;
      always_comb begin
         sh       = NW'(st_ff[k-1].e.dm) << (CW - k);
         st_in[k] = st_ff[k-1];
         if (st_ff[k-1].rem_x >= sh) begin
            st_in[k].rem_x        = st_ff[k-1].rem_x - sh;
            st_in[k].q_x[CW - k]  = 1'b1;
         end
         if (st_ff[k-1].rem_y >= sh) begin
            st_in[k].rem_y        = st_ff[k-1].rem_y - sh;
            st_in[k].q_y[CW - k]  = 1'b1;
         end
      end
   end

   always_comb begin
      qs_x = st_ff[CW].e.neg_x ? -$signed({1'b0, st_ff[CW].q_x})
                               : $signed({1'b0, st_ff[CW].q_x});
      qs_y = st_ff[CW].e.neg_y ? -$signed({1'b0, st_ff[CW].q_y})
                               : $signed({1'b0, st_ff[CW].q_y});
      hit = !st_ff[CW].e.det_zero && !st_ff[CW].ovf
         && qs_x >= (CW+1)'(st_ff[CW].e.bnd.ax_lo) && qs_x <= (CW+1)'(st_ff[CW].e.bnd.ax_hi)
         && qs_x >= (CW+1)'(st_ff[CW].e.bnd.bx_lo) && qs_x <= (CW+1)'(st_ff[CW].e.bnd.bx_hi)
         && qs_y >= (CW+1)'(st_ff[CW].e.bnd.ay_lo) && qs_y <= (CW+1)'(st_ff[CW].e.bnd.ay_hi)
         && qs_y >= (CW+1)'(st_ff[CW].e.bnd.by_lo) && qs_y <= (CW+1)'(st_ff[CW].e.bnd.by_hi);
      rsp_in.hit     = hit;
      rsp_in.cross_x = hit ? qs_x[CW-1:0] : '0;
      rsp_in.cross_y = hit ? qs_y[CW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[CW-1:0], pop};
         rsp_valid_ff <= vld_ff[CW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CW; k++) begin
            st_ff[k] <= st_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

### src/segment_intersection_unit.sv
// segment_intersection_unit: top level of the segment intersection unit
`timescale 1ns / 1ps
// Takes one pair of line segments per transfer (signed 16-bit fixed point
// endpoints) and returns one result per pair: a hit flag and the crossing
// point, truncated toward zero, or zeros when the segments are parallel,
// degenerate or cross outside either segment's x or y range. A new pair is
// taken every cycle while req_ready is high, which is low only while the
// last front stage is held by a full queue. Five front stages form the
// determinant and numerators, and seventeen back stages run a restoring
// divider one quotient bit per stage (plus an overflow check), then the
// result register. The two-entry queue lets the front keep accepting
// while the back waits on rsp_ready; at most 25 pairs are in flight.
module segment_intersection_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sgi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgi_pkg::rsp_type rsp_data
);

   // in-flight capacity: front stages, queue, back stages, result register
   localparam int CAP = 5 + sgi_pkg::QUEUE_DEPTH + sgi_pkg::CW + 2;
   localparam int OW  = $clog2(CAP + 1);

   sgi_pkg::queue_status_type qstat;
   sgi_pkg::entry_type        push_data, head;
   logic                      push, pop;
   logic [OW-1:0]             outst_ff, outst_in;

   // front: accept and classify
   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   sgi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   // back: divide, check bounds, hold the result
   sgi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // outstanding transfer count, for checking only
   always_comb begin
      outst_in = outst_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         outst_in = outst_ff + 1'b1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         outst_in = outst_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   // a miss always carries zero coordinates
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.cross_x == '0 && rsp_data.cross_y == '0)
      else $error("miss with nonzero coordinates");

   // no response without a pair in flight
   a_no_invent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != '0)
      else $error("response with nothing outstanding");

   // never more pairs in flight than the pipeline holds
   a_capacity : assert property (@(posedge clock) disable iff (reset)
      outst_ff <= OW'(CAP))
      else $error("in-flight count exceeds capacity");

   // the queue never takes a push while full
   a_queue_push : assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("push into full queue");

endmodule
